FILE: rtl/core/vad_pkg.sv
// ----------------------------------------------------------------------------
// vad_pkg: shared definitions for the Vigenere alphabet decryptor
// Command, status and register codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package vad_pkg;

  localparam int ALPHA_MAX_DEFAULT = 128;
  localparam int KEY_MAX_DEFAULT   = 64;

  localparam int CHAR_W      = 8;  // alphabet, key and cipher bytes
  localparam int INDEX_W     = 7;  // table slot of a load request
  localparam int ALPHA_LEN_W = 8;  // alphabet_length register
  localparam int KEY_LEN_W   = 7;  // key_length register
  localparam int ALEN_W      = 9;  // saturated alphabet length, up to 256
  localparam int POS_W       = 8;  // match position, alphabet of up to 256
  localparam int KEY_POS_W   = 6;  // key position register
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;

  localparam logic [ALPHA_LEN_W-1:0] ALPHA_LEN_RESET = 8'd26;
  localparam logic [KEY_LEN_W-1:0]   KEY_LEN_RESET   = 7'd1;

  typedef enum logic [1:0] {
    CMD_LOAD_ALPHA = 2'd0,
    CMD_LOAD_KEY   = 2'd1,
    CMD_DECRYPT    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_CIPHER = 2'd1,
    STATUS_NO_KEY    = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ALPHA_LEN = 4'd0,
    REG_KEY_LEN   = 4'd1
  } cfg_reg_t;

  // Result of one alphabet search.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } match_t;

endpackage

FILE: rtl/core/vigenere_alphabet_decrypt.sv
// ----------------------------------------------------------------------------
// vigenere_alphabet_decrypt: Vigenere decryption over a loadable alphabet
// Load requests fill the alphabet and key tables; decrypt requests return
// one plaintext byte and a status each.
// ----------------------------------------------------------------------------
// Usage. Requests enter on the in_valid/in_ready channel with cmd, index and
// value. Load requests (alphabet entry or key byte) produce no result; a
// decrypt request produces exactly one result on out_valid/out_ready with
// plain_char and status. A byte or key byte that is not in the alphabet
// returns an error status with plain_char zero and keeps the key position.
// The cfg channel writes alphabet_length and key_length; it is always ready
// and must only be used while no decrypt request is in flight.
// Timing. The block takes one request per cycle unless the output stalls.
// A decrypt result passes the input, position and output registers. The rate
// is set by the key position loop: the alphabet search of a request, the key
// position update and the key RAM read address of the next request form one
// path. Reset clears the pipeline and key position, resets the length
// registers; the tables keep whatever they hold and must be loaded before
// use. When the receiver stalls, the result waits in the output register
// while the two stages in front of it keep filling, after which in_ready drops.
// ----------------------------------------------------------------------------
module vigenere_alphabet_decrypt #(
  parameter int ALPHA_MAX = vad_pkg::ALPHA_MAX_DEFAULT,
  parameter int KEY_MAX   = vad_pkg::KEY_MAX_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      cmd,
  input  logic [vad_pkg::INDEX_W-1:0]     index,
  input  logic [vad_pkg::CHAR_W-1:0]      value,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vad_pkg::CHAR_W-1:0]      plain_char,
  output logic [1:0]                      status,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vad_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW    = $clog2(ALPHA_MAX);
  localparam int KW    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int SUM_W = vad_pkg::ALEN_W + 1;

  // Configuration registers.
  logic [vad_pkg::ALPHA_LEN_W-1:0] alphabet_length;
  logic [vad_pkg::KEY_LEN_W-1:0]   key_length;

  // Stage 0: input register.
  logic                          s0_valid;
  vad_pkg::cmd_t                 s0_cmd;
  logic [vad_pkg::INDEX_W-1:0]   s0_index;
  logic [vad_pkg::CHAR_W-1:0]    s0_value;

  // Stage 1: matched positions.
  logic                          s1_valid;
  logic [AW-1:0]                 s1_sym;
  logic [AW-1:0]                 s1_key;
  vad_pkg::status_t              s1_status;

  // Stage 2: output register; the byte itself comes from the alphabet RAM.
  logic                          s2_valid;
  vad_pkg::status_t              s2_status;

  logic                          s0_adv;
  logic                          s1_adv;

  logic [vad_pkg::CHAR_W-1:0]    alpha_q [ALPHA_MAX];
  logic                          alpha_we;
  logic [vad_pkg::CHAR_W-1:0]    alpha_rdata;

  logic [vad_pkg::KEY_POS_W-1:0] key_position;
  logic [vad_pkg::KEY_POS_W-1:0] key_position_next;
  logic [vad_pkg::KEY_POS_W:0]   kp_inc;
  logic [vad_pkg::KEY_POS_W-1:0] kp_wrap;
  logic                          key_we;
  logic [KW-1:0]                 key_raddr;
  logic [vad_pkg::CHAR_W-1:0]    key_rdata;
  logic                          key_bypass;
  logic [vad_pkg::CHAR_W-1:0]    key_bypass_data;
  logic [vad_pkg::CHAR_W-1:0]    key_char;

  logic [vad_pkg::ALEN_W-1:0]    alen;
  logic [vad_pkg::KEY_LEN_W-1:0] klen;

  vad_pkg::match_t               cipher_match;
  vad_pkg::match_t               key_match;
  vad_pkg::status_t              s0_status;

  logic [SUM_W-1:0]              wrap_sum;
  logic [AW-1:0]                 s1_pos;

  // --------------------------------------------------------------------------
  // Handshakes. Each stage moves on when the stage behind it is free or moves.
  // --------------------------------------------------------------------------
  assign s1_adv    = s1_valid && (!s2_valid || out_ready);
  assign s0_adv    = s0_valid && (!s1_valid || s1_adv);
  assign in_ready  = !s0_valid || s0_adv;
  assign out_valid = s2_valid;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration writes. An index beyond the register list is dropped.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_length <= vad_pkg::ALPHA_LEN_RESET;
      key_length      <= vad_pkg::KEY_LEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        vad_pkg::REG_ALPHA_LEN: alphabet_length <= cfg_data;
        vad_pkg::REG_KEY_LEN:   key_length      <= cfg_data[vad_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths as used: the alphabet length saturates at the table size, and
  // the key length is held between one and the key table size.
  always_comb begin
    if (32'(alphabet_length) > ALPHA_MAX) begin
      alen = vad_pkg::ALEN_W'(ALPHA_MAX);
    end else begin
      alen = vad_pkg::ALEN_W'(alphabet_length);
    end
    if (key_length == '0) begin
      klen = vad_pkg::KEY_LEN_W'(1);
    end else if (32'(key_length) > KEY_MAX) begin
      klen = vad_pkg::KEY_LEN_W'(KEY_MAX);
    end else begin
      klen = key_length;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_cmd   <= vad_pkg::cmd_t'(cmd);
      s0_index <= index;
      s0_value <= value;
    end
  end

  // --------------------------------------------------------------------------
  // Tables. The alphabet lives in flip-flops for the parallel search, with a
  // copy in RAM for the lookup of the plaintext byte. Loads to a slot beyond
  // the table are dropped.
  // --------------------------------------------------------------------------
  assign alpha_we = s0_adv && (s0_cmd == vad_pkg::CMD_LOAD_ALPHA) && (32'(s0_index) < ALPHA_MAX);
  assign key_we   = s0_adv && (s0_cmd == vad_pkg::CMD_LOAD_KEY) && (32'(s0_index) < KEY_MAX);

  always_ff @(posedge clk) begin
    if (alpha_we) begin
      alpha_q[AW'(s0_index)] <= s0_value;
    end
  end

  // The key RAM is read every cycle at the position the next request uses.
  // A key load resets that position, and if it writes the same slot the new
  // byte is forwarded around the read-first RAM.
  assign key_raddr = KW'(key_position_next);

  vad_ram #(
    .WIDTH (vad_pkg::CHAR_W),
    .DEPTH (KEY_MAX)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (KW'(s0_index)),
    .wdata (s0_value),
    .re    (1'b1),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bypass <= 1'b0;
    end else begin
      key_bypass <= key_we && (KW'(s0_index) == key_raddr);
    end
  end

  always_ff @(posedge clk) begin
    key_bypass_data <= s0_value;
  end

  assign key_char = key_bypass ? key_bypass_data : key_rdata;

  // --------------------------------------------------------------------------
  // Alphabet search for the cipher byte and the current key byte.
  // --------------------------------------------------------------------------
  vad_match #(
    .ENTRIES (ALPHA_MAX)
  ) u_cipher_match (
    .entries  (alpha_q),
    .count    (alen),
    .key_char (s0_value),
    .result   (cipher_match)
  );

  vad_match #(
    .ENTRIES (ALPHA_MAX)
  ) u_key_match (
    .entries  (alpha_q),
    .count    (alen),
    .key_char (key_char),
    .result   (key_match)
  );

  // A missing cipher byte is reported ahead of a missing key byte.
  always_comb begin
    if (!cipher_match.found) begin
      s0_status = vad_pkg::STATUS_NO_CIPHER;
    end else if (!key_match.found) begin
      s0_status = vad_pkg::STATUS_NO_KEY;
    end else begin
      s0_status = vad_pkg::STATUS_OK;
    end
  end

  // --------------------------------------------------------------------------
  // Key position. It steps on a good decrypt and wraps at the key length; a
  // position left beyond a shrunk key length is used once and then wraps.
  // --------------------------------------------------------------------------
  assign kp_inc  = {1'b0, key_position} + (vad_pkg::KEY_POS_W + 1)'(1);
  assign kp_wrap = (kp_inc >= klen) ? '0 : kp_inc[vad_pkg::KEY_POS_W-1:0];

  always_comb begin
    key_position_next = key_position;
    if (s0_adv) begin
      case (s0_cmd)
        vad_pkg::CMD_LOAD_KEY: key_position_next = '0;
        vad_pkg::CMD_DECRYPT: begin
          if (s0_status == vad_pkg::STATUS_OK) begin
            key_position_next = kp_wrap;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position <= '0;
    end else begin
      key_position <= key_position_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: positions found. Only decrypt requests enter.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s0_adv) begin
      s1_valid <= (s0_cmd == vad_pkg::CMD_DECRYPT);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s1_sym    <= AW'(cipher_match.pos);
      s1_key    <= AW'(key_match.pos);
      s1_status <= s0_status;
    end
  end

  // Plaintext position: (symbol + length - key) mod length, one subtraction
  // or the other, since both positions are below the length.
  assign wrap_sum = SUM_W'(s1_sym) + SUM_W'(alen) - SUM_W'(s1_key);
  assign s1_pos   = (s1_sym >= s1_key) ? (s1_sym - s1_key) : AW'(wrap_sum);

  // The RAM is read-first, so a later alphabet load in the same cycle does
  // not disturb the byte read for this request.
  vad_ram #(
    .WIDTH (vad_pkg::CHAR_W),
    .DEPTH (ALPHA_MAX)
  ) u_alpha_ram (
    .clk   (clk),
    .we    (alpha_we),
    .waddr (AW'(s0_index)),
    .wdata (s0_value),
    .re    (s1_adv),
    .raddr (s1_pos),
    .rdata (alpha_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 2: result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (out_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_status <= s1_status;
    end
  end

  assign plain_char = (s2_status == vad_pkg::STATUS_OK) ? alpha_rdata : '0;
  assign status     = 2'(s2_status);

`ifndef NO_ASSERTIONS
  // A key load always restarts the key at its first byte.
  a_key_load_restarts: assert property (@(posedge clk) disable iff (rst)
    (s0_adv && (s0_cmd == vad_pkg::CMD_LOAD_KEY)) |=> (key_position == '0))
    else $error("key position not cleared by a key load");

  // The key position moves only when a request leaves stage 0.
  a_key_pos_holds: assert property (@(posedge clk) disable iff (rst)
    !s0_adv |=> $stable(key_position))
    else $error("key position changed without a request");

  // A good decrypt points inside the alphabet in use.
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_status == vad_pkg::STATUS_OK)) |-> (vad_pkg::ALEN_W'(s1_pos) < alen))
    else $error("plaintext position beyond alphabet length");

  // A stalled result keeps its byte and status.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !out_ready) |=> (s2_valid && $stable(plain_char) && $stable(s2_status)))
    else $error("stalled result changed");
`endif

endmodule

FILE: rtl/core/vad_ram.sv
// ----------------------------------------------------------------------------
// vad_ram: generic single write port RAM with registered read
// Read-first: a read and a write to the same address return the old data.
// ----------------------------------------------------------------------------
module vad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/vad_match.sv
// ----------------------------------------------------------------------------
// vad_match: parallel first-match search over the alphabet entries
// Compares a byte against every entry in use and encodes the lowest hit.
// ----------------------------------------------------------------------------
module vad_match #(
  parameter int ENTRIES = 128
) (
  input  logic [vad_pkg::CHAR_W-1:0] entries [ENTRIES],
  input  logic [vad_pkg::ALEN_W-1:0] count,
  input  logic [vad_pkg::CHAR_W-1:0] key_char,
  output vad_pkg::match_t            result
);

  logic [ENTRIES-1:0] hit;
  logic [ENTRIES-1:0] first;

  // A zero byte never matches.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = (key_char != '0) && (vad_pkg::ALEN_W'(i) < count) && (entries[i] == key_char);
    end
  end

  // Isolate the lowest set bit, then encode it.
  assign first = hit & (~hit + ENTRIES'(1));

  always_comb begin
    result.found = |hit;
    result.pos   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (first[i]) begin
        result.pos = result.pos | vad_pkg::POS_W'(i);
      end
    end
  end

endmodule
